FILE: sv/fts_pkg.sv
// Shared constants and types for the firmware trailer scanner.
package fts_pkg;

    // Width of the byte position counter (saturates at all ones)
    localparam int OFFSET_BITS   = 32;
    localparam int TRAILER_BYTES = 56;
    // Trailer bytes captured after the magic word and length
    localparam int CAPTURE_LEN   = TRAILER_BYTES - 8;
    localparam int CAPTURE_BITS  = CAPTURE_LEN * 8;

    localparam logic [31:0] MAGIC_RESET = 32'h46446E45;

    // Bit offsets of the trailer fields inside the captured bytes
    localparam int HASH_LSB    = 0;
    localparam int VERSION_LSB = 64;
    localparam int TARGET_LSB  = 96;
    localparam int HWID_LSB    = 128;

    // Result tdata: 257 field bits padded to 33 bytes
    localparam int RES_DATA_W  = 264;

    typedef logic [CAPTURE_BITS-1:0] trailer_t;

    // Snapshot handed from the scanner to the result stage
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] trailer_offset;
        logic [31:0] image_length;
        trailer_t    trailer;
    } result_load_t;

endpackage

FILE: sv/fts_scan.sv
// Byte window, position counter, trailer search and capture shift line.
module fts_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_region,
    input  logic [31:0]          magic_word,
    output fts_pkg::result_load_t load
);
    import fts_pkg::*;

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] WIN_SPAN = OFFSET_BITS'(7);
    localparam logic [5:0] CAP_LAST = 6'(CAPTURE_LEN);

    logic [63:0]            win_reg, win_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [1:0]             phase_reg, phase_next;
    logic [5:0]             cap_cnt_reg, cap_cnt_next;
    logic [OFFSET_BITS-1:0] match_reg, match_next;
    trailer_t               trail_reg, trail_next;

    logic [OFFSET_BITS-1:0] cand_off;
    logic                   pos_exact;
    logic                   hit;
    logic [32:0]            img_sum;

    // Shift the new byte into the top of the window and test for a candidate
    always_comb
    begin
        win_next  = {data_byte, win_reg[63:8]};
        cand_off  = pos_reg - WIN_SPAN;
        pos_exact = (pos_reg >= WIN_SPAN) && (pos_reg != POS_MAX);
        hit       = pos_exact && (win_next[31:0] == magic_word)
                    && (win_next[63:32] == 32'(cand_off));
        pos_next  = (pos_reg != POS_MAX) ? pos_reg + OFFSET_BITS'(1) : pos_reg;
    end

    // Advance the scan phase and the capture count
    always_comb
    begin
        phase_next   = phase_reg;
        cap_cnt_next = cap_cnt_reg;
        match_next   = match_reg;
        trail_next   = trail_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (hit)
                begin
                    match_next   = cand_off;
                    cap_cnt_next = '0;
                    phase_next   = PH_CAPTURE;
                end
            end
            PH_CAPTURE:
            begin
                trail_next   = {data_byte, trail_reg[CAPTURE_BITS-1:8]};
                cap_cnt_next = cap_cnt_reg + 6'd1;
                if (cap_cnt_next >= CAP_LAST)
                    phase_next = PH_DONE;
            end
            default:
            begin
                // Complete: ignore bytes until the end of the region
            end
        endcase
    end

    // Build the result snapshot on the last byte of a region
    always_comb
    begin
        img_sum             = {1'b0, 32'(match_next)} + 33'(TRAILER_BYTES);
        load.valid          = accept && end_of_region;
        load.found          = (phase_next == PH_DONE);
        load.trailer_offset = load.found ? 32'(match_next) : '0;
        load.image_length   = !load.found ? '0 : (img_sum[32] ? '1 : img_sum[31:0]);
        load.trailer        = load.found ? trail_next : '0;
    end

    // Hold scan state; clear it after the end of a region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            pos_reg     <= '0;
            phase_reg   <= PH_SEARCH;
            cap_cnt_reg <= '0;
            match_reg   <= '0;
        end
        else if (accept)
        begin
            if (end_of_region)
            begin
                win_reg     <= '0;
                pos_reg     <= '0;
                phase_reg   <= PH_SEARCH;
                cap_cnt_reg <= '0;
                match_reg   <= '0;
            end
            else
            begin
                win_reg     <= win_next;
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                cap_cnt_reg <= cap_cnt_next;
                match_reg   <= match_next;
            end
        end
    end

    // Capture shift line: after all trailer bytes the first one sits lowest
    always_ff @(posedge clk)
    begin
        if (accept)
            trail_reg <= trail_next;
    end

endmodule

FILE: sv/fts_result.sv
// Result holding stage that sends one or four result transactions per region.
module fts_result
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fts_pkg::result_load_t        load,
    output logic                         can_load,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fts_pkg::RES_DATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);
    import fts_pkg::*;

    logic        busy_reg;
    logic [1:0]  idx_reg;
    logic        found_reg;
    logic [31:0] off_reg;
    logic [31:0] img_reg;
    trailer_t    trail_reg;

    logic        take;
    logic        last_item;
    logic [63:0] hw_word;

    assign last_item = !found_reg || (idx_reg == 2'd3);
    assign take      = busy_reg && m_tready;
    assign can_load  = !busy_reg || (m_tready && last_item);

    // Select the hardware id slice for the current transaction
    always_comb
    begin
        case (idx_reg)
            2'd0:    hw_word = trail_reg[HWID_LSB       +: 64];
            2'd1:    hw_word = trail_reg[HWID_LSB + 64  +: 64];
            2'd2:    hw_word = trail_reg[HWID_LSB + 128 +: 64];
            default: hw_word = trail_reg[HWID_LSB + 192 +: 64];
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_item;
    assign m_tuser  = idx_reg;
    assign m_tdata  = {7'd0, hw_word,
                       trail_reg[TARGET_LSB +: 32],
                       trail_reg[VERSION_LSB +: 32],
                       trail_reg[HASH_LSB +: 64],
                       img_reg, off_reg, found_reg};

    // Advance the transaction index; reload on a new region result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (last_item)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            found_reg <= load.found;
            off_reg   <= load.trailer_offset;
            img_reg   <= load.image_length;
            trail_reg <= load.trailer;
        end
    end

    a_notfound_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !found_reg |-> idx_reg == 2'd0)
        else $error("not-found result past its first transaction");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |=> busy_reg && idx_reg == 2'd0)
        else $error("result load did not start a new run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && idx_reg == $past(idx_reg) + 2'd1)
        else $error("result run broke before its last transaction");

endmodule

FILE: sv/firmware_trailer_scanner.sv
// Top level of the firmware trailer scanner.
// Streams a flash region in one byte per transaction (tlast marks the final
// byte) and searches for the first offset where the magic word appears and the
// following little-endian length equals that offset; the 48 trailer bytes after
// it are then captured. The window compare and the capture shift are one
// register stage. On the final byte the result stage loads and sends four
// transactions (one per hardware id word, tuser numbers them) or a single
// all-zero not-found transaction. A final byte is taken only once the result
// stage is free or its last transaction is being taken; other bytes are taken
// every cycle, also while results drain. Write magic_word only while the block
// is idle.
module firmware_trailer_scanner
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: magic word, first marker byte lowest
    input  logic                             magic_word_we,
    input  logic [31:0]                      magic_word_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic                             s_tlast,  // end_of_region
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] found, [32:1] trailer_offset, [64:33] image_length,
    // [128:65] trailer_hash, [160:129] firmware_version, [192:161] target_ident,
    // [256:193] hardware_id_word, [263:257] zero
    output logic [fts_pkg::RES_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser,  // [1:0] word_number
    output logic                             m_tlast   // last_of_run
);
    import fts_pkg::*;

    logic         [31:0] magic_word_reg;
    logic                can_load;
    logic                s_accept;
    result_load_t        load;

    // Hold the configured magic word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_word_reg <= MAGIC_RESET;
        else if (magic_word_we)
            magic_word_reg <= magic_word_wdata;
    end

    // Stall a final byte until the result stage can take its snapshot
    assign s_tready = !s_tlast || can_load;
    assign s_accept = s_tvalid && s_tready;

    fts_scan u_scan
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .data_byte     (s_tdata),
        .end_of_region (s_tlast),
        .magic_word    (magic_word_reg),
        .load          (load)
    );

    fts_result u_result
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
